// File: rtl/tlca_pkg.sv
// Shared constants and types for the tree LCA binary-lifting unit.
// Field widths, default sizes, command codes, range-reduction helper.
// No dependencies.
package tlca_pkg;

    localparam int NODE_IN_W       = 10;
    localparam int DEPTH_W         = 10;
    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_LIFT_LEVELS = 10;
    localparam int WRAP_W          = 20;
    localparam int WRAP_K_W        = 4;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // largest shift k with m << k still below the input node range
    function automatic int wrap_top(input int m);
        int k;
        k = 0;
        for (int i = 0; i < NODE_IN_W; i++) begin
            if ((m << i) < (1 << NODE_IN_W))
                k = i;
        end
        return k;
    endfunction

endpackage

// File: rtl/tlca_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tlca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/tree_lca_binary_lifting_unit.sv
// Lowest common ancestor by binary lifting: sequencer, working registers, output register.
// Depends on tlca_pkg and tlca_ram (ancestor table and depth store).
//
// An add item (command 0) stores node_a with parent node_b (the root is its own parent), and a
// query item (command 1) yields one ancestor item; in_stall is held after acceptance until the
// sequencer is back in its idle state. A query takes longer when the previous ancestor is still
// held in the output register. Both are paced by the single read port of the ancestor table, one
// table read per lifting level, with the two nodes of a query read in turn. When MAX_NODES is
// below 1024, node numbers are first reduced modulo MAX_NODES by one compare-subtract per cycle.
// One item is worked at a time; a finished result waits in the output register while the next
// item is taken. Parents must be added before their children, and no clearing pass is needed
// after reset.
module tree_lca_binary_lifting_unit
    import tlca_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [NODE_IN_W-1:0] node_a,
    input  logic [NODE_IN_W-1:0] node_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NODE_IN_W-1:0] ancestor
);

    localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int TBL_DEPTH = MAX_NODES << LVL_W;
    localparam int TBL_AW    = NODE_W + LVL_W;
    localparam bit NEED_WRAP = MAX_NODES < (1 << NODE_IN_W);
    localparam logic [WRAP_K_W-1:0] WRAP_TOP = WRAP_K_W'(wrap_top(MAX_NODES));
    localparam logic [LVL_W-1:0]    LVL_LAST = LVL_W'(LIFT_LEVELS - 1);
    localparam logic [WRAP_W-1:0]   WRAP_M   = WRAP_W'(MAX_NODES);

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_WRAP   = 19'h00002,
        S_LOAD   = 19'h00004,
        S_ADD0   = 19'h00008,
        S_ADD1   = 19'h00010,
        S_ADD_RD = 19'h00020,
        S_ADD_WR = 19'h00040,
        S_QDA    = 19'h00080,
        S_QDB    = 19'h00100,
        S_QCMP   = 19'h00200,
        S_EQ     = 19'h00400,
        S_EQ_WR  = 19'h00800,
        S_CHK    = 19'h01000,
        S_LU     = 19'h02000,
        S_LV     = 19'h04000,
        S_LCMP   = 19'h08000,
        S_FIN_RD = 19'h10000,
        S_FIN    = 19'h20000,
        S_OUT    = 19'h40000
    } state_t;

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NODE_IN_W-1:0]  anc_reg, anc_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [NODE_IN_W-1:0]  a_raw_reg, a_raw_next;
    logic [NODE_IN_W-1:0]  b_raw_reg, b_raw_next;
    logic [WRAP_K_W-1:0]   wrap_k_reg, wrap_k_next;
    logic [NODE_W-1:0]     u_reg, u_next;
    logic [NODE_W-1:0]     v_reg, v_next;
    logic [NODE_W-1:0]     au_reg, au_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [DEPTH_W-1:0]    d_reg, d_next;
    logic [DEPTH_W-1:0]    k_reg, k_next;

    logic [WRAP_W-1:0]     wrap_sub;
    logic                  tbl_we;
    logic [TBL_AW-1:0]     tbl_waddr, tbl_raddr;
    logic [NODE_W-1:0]     tbl_wdata, tbl_rdata;
    logic                  dep_we;
    logic [NODE_W-1:0]     dep_waddr, dep_raddr;
    logic [DEPTH_W-1:0]    dep_wdata, dep_rdata;
    logic                  out_free;

    tlca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TBL_DEPTH),
        .AW    (TBL_AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    tlca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES),
        .AW    (NODE_W)
    ) u_depth (
        .clk   (clk),
        .we    (dep_we),
        .waddr (dep_waddr),
        .wdata (dep_wdata),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign ancestor  = anc_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign wrap_sub  = WRAP_M << wrap_k_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        anc_next       = anc_reg;
        cmd_next       = cmd_reg;
        a_raw_next     = a_raw_reg;
        b_raw_next     = b_raw_reg;
        wrap_k_next    = wrap_k_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        au_next        = au_reg;
        lvl_next       = lvl_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = {u_reg, lvl_reg};
        tbl_wdata      = v_reg;
        tbl_raddr      = {u_reg, lvl_reg};
        dep_we         = 1'b0;
        dep_waddr      = u_reg;
        dep_wdata      = '0;
        dep_raddr      = u_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd_t'(command);
                    a_raw_next  = node_a;
                    b_raw_next  = node_b;
                    wrap_k_next = WRAP_TOP;
                    state_next  = NEED_WRAP ? S_WRAP : S_LOAD;
                end
            end
            S_WRAP:
            begin
                if ({{(WRAP_W-NODE_IN_W){1'b0}}, a_raw_reg} >= wrap_sub)
                    a_raw_next = a_raw_reg - wrap_sub[NODE_IN_W-1:0];
                if ({{(WRAP_W-NODE_IN_W){1'b0}}, b_raw_reg} >= wrap_sub)
                    b_raw_next = b_raw_reg - wrap_sub[NODE_IN_W-1:0];
                if (wrap_k_reg == '0)
                    state_next = S_LOAD;
                else
                    wrap_k_next = wrap_k_reg - 1'b1;
            end
            S_LOAD:
            begin
                u_next     = NODE_W'(a_raw_reg);
                v_next     = NODE_W'(b_raw_reg);
                lvl_next   = '0;
                state_next = (cmd_reg == CMD_ADD) ? S_ADD0 : S_QDA;
            end
            S_ADD0:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = {u_reg, {LVL_W{1'b0}}};
                tbl_wdata  = v_reg;
                dep_raddr  = v_reg;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                dep_we    = 1'b1;
                dep_waddr = u_reg;
                if (u_reg == v_reg)
                    dep_wdata = '0;
                else if (dep_rdata == DEPTH_MAX)
                    dep_wdata = DEPTH_MAX;
                else
                    dep_wdata = dep_rdata + 1'b1;
                state_next = (LIFT_LEVELS > 1) ? S_ADD_RD : S_IDLE;
            end
            S_ADD_RD:
            begin
                tbl_raddr  = {v_reg, lvl_reg};
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = {u_reg, LVL_W'(lvl_reg + 1'b1)};
                tbl_wdata = tbl_rdata;
                v_next    = tbl_rdata;
                lvl_next  = lvl_reg + 1'b1;
                if (LVL_W'(lvl_reg + 1'b1) == LVL_LAST)
                    state_next = S_IDLE;
                else
                    state_next = S_ADD_RD;
            end
            S_QDA:
            begin
                dep_raddr  = u_reg;
                state_next = S_QDB;
            end
            S_QDB:
            begin
                dep_raddr  = v_reg;
                d_next     = dep_rdata;
                state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if (d_reg < dep_rdata)
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                    k_next = dep_rdata - d_reg;
                end
                else
                begin
                    k_next = d_reg - dep_rdata;
                end
                lvl_next   = '0;
                state_next = S_EQ;
            end
            S_EQ:
            begin
                tbl_raddr = {u_reg, lvl_reg};
                if (k_reg[0])
                begin
                    state_next = S_EQ_WR;
                end
                else
                begin
                    k_next = k_reg >> 1;
                    if (lvl_reg == LVL_LAST)
                        state_next = S_CHK;
                    else
                        lvl_next = lvl_reg + 1'b1;
                end
            end
            S_EQ_WR:
            begin
                u_next = tbl_rdata;
                k_next = k_reg >> 1;
                if (lvl_reg == LVL_LAST)
                begin
                    state_next = S_CHK;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_EQ;
                end
            end
            S_CHK:
            begin
                lvl_next   = LVL_LAST;
                state_next = (u_reg == v_reg) ? S_OUT : S_LU;
            end
            S_LU:
            begin
                tbl_raddr  = {u_reg, lvl_reg};
                state_next = S_LV;
            end
            S_LV:
            begin
                tbl_raddr  = {v_reg, lvl_reg};
                au_next    = tbl_rdata;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                if (au_reg != tbl_rdata)
                begin
                    u_next = au_reg;
                    v_next = tbl_rdata;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_LU;
                end
            end
            S_FIN_RD:
            begin
                tbl_raddr  = {u_reg, {LVL_W{1'b0}}};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                u_next     = tbl_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    anc_next       = NODE_IN_W'(u_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        anc_reg    <= anc_next;
        cmd_reg    <= cmd_next;
        a_raw_reg  <= a_raw_next;
        b_raw_reg  <= b_raw_next;
        wrap_k_reg <= wrap_k_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        au_reg     <= au_next;
        lvl_reg    <= lvl_next;
        d_reg      <= d_next;
        k_reg      <= k_next;
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start the sequencer");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_depth_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        dep_we |-> $past(state_reg == S_ADD0))
        else $error("depth written without a parent depth read");

    a_wrapped_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ((a_raw_reg < MAX_NODES) && (b_raw_reg < MAX_NODES)))
        else $error("node number not reduced below the table size");

endmodule

// File: bench/tree_lca_binary_lifting_unit_test.sv
// Self-checking bench for tree_lca_binary_lifting_unit: builds trees by parent links, runs
// LCA queries against an in-bench binary-lifting predictor, with random idling on both sides.
// Depends on tlca_pkg and the unit RTL.
`timescale 1ns / 1ps

module tree_lca_binary_lifting_unit_test;
    import tlca_pkg::*;

    localparam int NODES       = DEF_MAX_NODES;
    localparam int LEVELS      = DEF_LIFT_LEVELS;
    localparam int CHAIN_LEN   = 560;
    localparam int RANDOM_GOAL = 150;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 1500000;

    typedef logic [NODE_IN_W-1:0] node_t;

    logic  clk;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    logic  command   = CMD_ADD;
    node_t node_a    = '0;
    node_t node_b    = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    node_t ancestor;

    logic [DEPTH_W-1:0] depth_of [NODES];
    node_t              lift_up  [NODES][LEVELS];
    node_t              ancestor_due [$];
    bit                 added [NODES];
    node_t              added_list [$];

    bit idle_off = 1'b0;
    bit hold_out = 1'b0;
    int errors   = 0;
    int adds     = 0;
    int queries  = 0;
    int checked  = 0;
    int cycle_count = 0;

    tree_lca_binary_lifting_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .node_a    (node_a),
        .node_b    (node_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ancestor  (ancestor)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic node_t pick_known();
        return added_list[$urandom_range(0, added_list.size() - 1)];
    endfunction

    function automatic void tree_add(node_t v, node_t p);
        logic [DEPTH_W:0] d;
        if (v == p)
            d = '0;
        else
        begin
            d = {1'b0, depth_of[p]} + {{DEPTH_W{1'b0}}, 1'b1};
            if (d > {1'b0, DEPTH_MAX})
                d = {1'b0, DEPTH_MAX};
        end
        depth_of[v] = d[DEPTH_W-1:0];
        lift_up[v][0] = p;
        for (int i = 1; i < LEVELS; i++)
            lift_up[v][i] = lift_up[lift_up[v][i-1]][i-1];
        if (!added[v])
        begin
            added[v] = 1'b1;
            added_list = {added_list, v};
        end
    endfunction

    function automatic node_t lca_of(node_t u, node_t v);
        node_t t;
        node_t au;
        node_t av;
        logic [DEPTH_W-1:0] k;
        if (depth_of[u] < depth_of[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        k = depth_of[u] - depth_of[v];
        for (int i = 0; i < LEVELS; i++)
            if (k[i])
                u = lift_up[u][i];
        if (u == v)
            return u;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            au = lift_up[u][i];
            av = lift_up[v][i];
            if (au != av)
            begin
                u = au;
                v = av;
            end
        end
        return lift_up[u][0];
    endfunction

    task automatic send_item(cmd_t op, node_t a, node_t b);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        command  <= op;
        node_a   <= a;
        node_b   <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == CMD_ADD)
        begin
            tree_add(a, b);
            adds++;
        end
        else
        begin
            ancestor_due = {ancestor_due, lca_of(a, b)};
            queries++;
        end
        gap = idle_off ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // receiver: random stalls, one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                stall_left = LONG_HOLD;
                hold_out = 1'b0;
            end
            else if (stall_left == 0 && !idle_off)
                stall_left = pick_gap();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        node_t want;
        if (out_valid && !out_stall)
        begin
            if (ancestor_due.size() == 0)
            begin
                $display("%0t: ancestor %0d with nothing pending", $time, ancestor);
                errors++;
            end
            else
            begin
                want = ancestor_due.pop_front();
                checked++;
                if (ancestor !== want)
                begin
                    $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                             $time, want, ancestor);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tree_lca_binary_lifting_unit_test: errors");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(CMD_ADD, 10'd0, 10'd0);
        send_item(CMD_ADD, 10'd1023, 10'd1023);
        send_item(CMD_ADD, 10'd1, 10'd0);
        send_item(CMD_ADD, 10'd2, 10'd1);
        send_item(CMD_ADD, 10'd3, 10'd1);
        send_item(CMD_ADD, 10'd1022, 10'd1023);
        send_item(CMD_ADD, 10'd682, 10'd1022);
        send_item(CMD_QUERY, 10'd2, 10'd3);
        send_item(CMD_QUERY, 10'd0, 10'd0);
        send_item(CMD_QUERY, 10'd1023, 10'd1023);
        send_item(CMD_QUERY, 10'd3, 10'd0);
        send_item(CMD_QUERY, 10'd0, 10'd3);
        send_item(CMD_QUERY, 10'd682, 10'd1023);
        send_item(CMD_QUERY, 10'd2, 10'd682);
        send_item(CMD_QUERY, 10'd1023, 10'd0);
        send_item(CMD_ADD, 10'd3, 10'd2);
        send_item(CMD_QUERY, 10'd3, 10'd1);
        send_item(CMD_QUERY, 10'd2, 10'd3);
        send_item(CMD_ADD, 10'd341, 10'd341);
        send_item(CMD_ADD, 10'd1021, 10'd341);
        send_item(CMD_QUERY, 10'd1021, 10'd1022);
        send_item(CMD_QUERY, 10'd341, 10'd1021);
    endtask

    // one chain deeper than the top lifting level, then close it into a loop
    task automatic test_deep_chain();
        int order [NODES];
        int j;
        int t;
        for (int i = 0; i < NODES; i++)
            order[i] = i;
        for (int i = NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        idle_off = 1'b1;
        send_item(CMD_ADD, node_t'(order[0]), node_t'(order[0]));
        for (int i = 1; i < CHAIN_LEN; i++)
            send_item(CMD_ADD, node_t'(order[i]), node_t'(order[i-1]));
        idle_off = 1'b0;
        send_item(CMD_QUERY, node_t'(order[CHAIN_LEN-1]), node_t'(order[0]));
        send_item(CMD_QUERY, node_t'(order[0]), node_t'(order[CHAIN_LEN-1]));
        send_item(CMD_QUERY, node_t'(order[CHAIN_LEN-1]), node_t'(order[512]));
        for (int i = 0; i < 20; i++)
            send_item(CMD_QUERY, node_t'(order[$urandom_range(0, CHAIN_LEN-1)]),
                      node_t'(order[$urandom_range(0, CHAIN_LEN-1)]));
        send_item(CMD_ADD, node_t'(order[0]), node_t'(order[CHAIN_LEN-1]));
        send_item(CMD_ADD, node_t'(order[1]), node_t'(order[0]));
        send_item(CMD_QUERY, node_t'(order[0]), node_t'(order[1]));
        send_item(CMD_QUERY, node_t'(order[1]), node_t'(order[CHAIN_LEN-1]));
        send_item(CMD_QUERY, node_t'(order[0]), node_t'(order[300]));
    endtask

    task automatic test_output_hold();
        hold_out = 1'b1;
        idle_off = 1'b1;
        for (int i = 0; i < 30; i++)
            send_item(CMD_QUERY, pick_known(), pick_known());
        idle_off = 1'b0;
    endtask

    task automatic test_random_forests(int goal);
        node_t members [$];
        node_t v;
        node_t p;
        node_t q;
        int sent;
        int size;
        sent = 0;
        while (sent < goal)
        begin
            idle_off = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                members.delete();
                v = node_t'($urandom_range(0, NODES-1));
                send_item(CMD_ADD, v, v);
                members = {members, v};
                size = $urandom_range(2, 40);
                for (int i = 1; i < size; i++)
                begin
                    v = node_t'($urandom_range(0, NODES-1));
                    if ($urandom_range(0, 1))
                        p = members[members.size()-1];
                    else
                        p = members[$urandom_range(0, members.size()-1)];
                    send_item(CMD_ADD, v, p);
                    members = {members, v};
                end
                size = size + $urandom_range(4, 20);
                for (int i = members.size(); i < size; i++)
                begin
                    p = members[$urandom_range(0, members.size()-1)];
                    if ($urandom_range(0, 99) < 85)
                        q = members[$urandom_range(0, members.size()-1)];
                    else
                        q = pick_known();
                    send_item(CMD_QUERY, p, q);
                end
                sent += size;
            end
            else
            begin
                for (int i = 0; i < 10; i++)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        v = pick_known();
                        p = pick_known();
                        send_item(CMD_QUERY, v, p);
                    end
                    else
                    begin
                        v = node_t'($urandom_range(0, NODES-1));
                        p = ($urandom_range(0, 3) == 0) ? v : pick_known();
                        send_item(CMD_ADD, v, p);
                    end
                end
                sent += 10;
            end
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_deep_chain();
        test_output_hold();
        test_random_forests(RANDOM_GOAL);

        @(negedge clk);
        in_valid <= 1'b0;
        while (ancestor_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (ancestor_due.size() != 0)
        begin
            $display("%0t: %0d ancestors never arrived", $time, ancestor_due.size());
            errors++;
        end

        $display("run: %0d node adds, %0d queries, %0d ancestors compared, %0d errors",
                 adds, queries, checked, errors);
        $display("run: covered a %0d-deep chain closed into a loop, random forests, long hold",
                 CHAIN_LEN);
        if (errors == 0)
            $display("tree_lca_binary_lifting_unit_test: clean");
        else
            $display("tree_lca_binary_lifting_unit_test: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tlca_pkg.sv
rtl/tlca_ram.sv
rtl/tree_lca_binary_lifting_unit.sv
bench/tree_lca_binary_lifting_unit_test.sv
